// File: hdl/nocnt_pkg.sv
package nocnt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH   = 256;
  localparam int unsigned DEF_MAX_KEY_BYTES = 30;

  localparam int unsigned NAME_W  = 64;
  localparam int unsigned NAME_N  = 4;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned USED_W  = 9;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned STAT_W  = 3;

  typedef enum logic {
    CMD_COUNT = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_COUNTED   = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDW,
    S_SCAN,
    S_FIN
  } state_e;

  typedef struct packed {
    status_e                         status;
    logic [INDEX_W-1:0]              index;
    logic [COUNT_W-1:0]              count;
    logic [NAME_N-1:0][NAME_W-1:0]   words;
    logic [LEN_W-1:0]                length;
    logic [USED_W-1:0]               used;
  } res_t;

endpackage

// File: hdl/nocnt_cmd_if.sv
interface nocnt_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [nocnt_pkg::NAME_W-1:0]   name_word0;
  logic [nocnt_pkg::NAME_W-1:0]   name_word1;
  logic [nocnt_pkg::NAME_W-1:0]   name_word2;
  logic [nocnt_pkg::NAME_W-1:0]   name_word3;
  logic [nocnt_pkg::LEN_W-1:0]    name_length;
  logic [nocnt_pkg::INDEX_W-1:0]  read_index;

  modport source (
    output valid, command, name_word0, name_word1, name_word2, name_word3,
           name_length, read_index,
    input  ready
  );

  modport sink (
    input  valid, command, name_word0, name_word1, name_word2, name_word3,
           name_length, read_index,
    output ready
  );
endinterface

// File: hdl/nocnt_rsp_if.sv
interface nocnt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [nocnt_pkg::STAT_W-1:0]   status;
  logic [nocnt_pkg::INDEX_W-1:0]  entry_index;
  logic [nocnt_pkg::COUNT_W-1:0]  entry_count;
  logic [nocnt_pkg::NAME_W-1:0]   out_word0;
  logic [nocnt_pkg::NAME_W-1:0]   out_word1;
  logic [nocnt_pkg::NAME_W-1:0]   out_word2;
  logic [nocnt_pkg::NAME_W-1:0]   out_word3;
  logic [nocnt_pkg::LEN_W-1:0]    out_length;
  logic [nocnt_pkg::USED_W-1:0]   entries_used;

  modport source (
    output valid, status, entry_index, entry_count, out_word0, out_word1,
           out_word2, out_word3, out_length, entries_used,
    input  ready
  );

  modport sink (
    input  valid, status, entry_index, entry_count, out_word0, out_word1,
           out_word2, out_word3, out_length, entries_used,
    output ready
  );
endinterface

// File: hdl/name_occurrence_count_table.sv
// channel  dir  modport  payload
// cmd_i    in   sink     command, name_word0..3, name_length, read_index
// rsp_o    out  source   status, entry_index, entry_count, out_word0..3,
//                        out_length, entries_used
//
// one transaction at a time; cmd_i.ready is high only while the engine is idle
// count: the table memory is read one entry per cycle
// read: S_RDW then S_FIN; empty name or bad index: straight to S_FIN, which waits for rsp_o to drain
// rsp_o is a register, the next transaction is taken while a result still waits
// rst_ni clears the fill level and control; the table itself needs no clearing
module name_occurrence_count_table #(
  parameter int unsigned TABLE_DEPTH   = nocnt_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned MAX_KEY_BYTES = nocnt_pkg::DEF_MAX_KEY_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nocnt_cmd_if.sink    cmd_i,
  nocnt_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned POS_W  =
    (FILL_W > nocnt_pkg::USED_W) ? FILL_W : nocnt_pkg::USED_W;
  localparam int unsigned KEY_W  = 8 * MAX_KEY_BYTES;
  localparam int unsigned ALL_W  = nocnt_pkg::NAME_N * nocnt_pkg::NAME_W;
  localparam int unsigned ENT_W  = KEY_W + nocnt_pkg::LEN_W + nocnt_pkg::COUNT_W;
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(TABLE_DEPTH);
  localparam logic [5:0]        MAX_LEN   = 6'(MAX_KEY_BYTES);

  function automatic logic [nocnt_pkg::INDEX_W-1:0] to_index(input logic [IDX_W-1:0] a);
    logic [POS_W-1:0] wide;
    wide = POS_W'(a);
    return wide[nocnt_pkg::INDEX_W-1:0];
  endfunction

  function automatic logic [nocnt_pkg::USED_W-1:0] to_used(input logic [FILL_W-1:0] a);
    logic [POS_W-1:0] wide;
    wide = POS_W'(a);
    return wide[nocnt_pkg::USED_W-1:0];
  endfunction

  nocnt_pkg::state_e state_q, state_d;
  logic [FILL_W-1:0]               fill_q, fill_d;
  logic [FILL_W-1:0]               rd_addr_q, rd_addr_d;
  logic                            cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0]                cmp_addr_q, cmp_addr_d;
  logic [KEY_W-1:0]                key_q, key_d;
  logic [nocnt_pkg::LEN_W-1:0]     len_q, len_d;
  nocnt_pkg::res_t                 pend_q, pend_d;
  nocnt_pkg::res_t                 out_q;
  logic                            out_valid_q;

  logic [ENT_W-1:0]                mem_q [TABLE_DEPTH];
  logic [ENT_W-1:0]                rdata_q;
  logic                            mem_re, mem_we;
  logic [IDX_W-1:0]                mem_raddr, mem_waddr;
  logic [ENT_W-1:0]                mem_wdata;

  logic                            accept, out_free, is_read;
  logic [nocnt_pkg::LEN_W-1:0]     len_c;
  logic [ALL_W-1:0]                name_all, name_mask;
  logic [KEY_W-1:0]                key_in;
  logic [POS_W-1:0]                idx_ext, fill_ext;
  logic                            idx_ok, hit, full, scan_more;
  logic [KEY_W-1:0]                r_key;
  logic [nocnt_pkg::LEN_W-1:0]     r_len;
  logic [nocnt_pkg::COUNT_W-1:0]   r_cnt, sat_cnt;

  assign cmd_i.ready = (state_q == nocnt_pkg::S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign is_read     = (cmd_i.command == nocnt_pkg::CMD_READ);

  assign len_c = ({1'b0, cmd_i.name_length} > MAX_LEN) ? MAX_LEN[nocnt_pkg::LEN_W-1:0]
                                                        : cmd_i.name_length;
  assign name_all = {cmd_i.name_word3, cmd_i.name_word2, cmd_i.name_word1, cmd_i.name_word0};

  always_comb begin
    for (int b = 0; b < ALL_W / 8; b++) begin
      name_mask[8*b +: 8] = (6'(b) < {1'b0, len_c}) ? name_all[8*b +: 8] : 8'h00;
    end
  end
  assign key_in = name_mask[KEY_W-1:0];

  assign idx_ext   = POS_W'(cmd_i.read_index);
  assign fill_ext  = POS_W'(fill_q);
  assign idx_ok    = idx_ext < fill_ext;

  assign r_key   = rdata_q[KEY_W-1:0];
  assign r_len   = rdata_q[KEY_W +: nocnt_pkg::LEN_W];
  assign r_cnt   = rdata_q[KEY_W + nocnt_pkg::LEN_W +: nocnt_pkg::COUNT_W];
  assign sat_cnt = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;

  assign hit       = cmp_v_q && (r_len == len_q) && (r_key == key_q);
  assign full      = (fill_q == FULL_FILL);
  assign scan_more = rd_addr_q < fill_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nocnt_pkg::S_IDLE: begin
        if (accept) begin
          if (is_read) begin
            state_d = idx_ok ? nocnt_pkg::S_RDW : nocnt_pkg::S_FIN;
          end else begin
            state_d = (len_c == '0) ? nocnt_pkg::S_FIN : nocnt_pkg::S_SCAN;
          end
        end
      end
      nocnt_pkg::S_RDW: state_d = nocnt_pkg::S_FIN;
      nocnt_pkg::S_SCAN: begin
        if (hit || !scan_more) begin
          state_d = nocnt_pkg::S_FIN;
        end
      end
      nocnt_pkg::S_FIN: begin
        if (out_free) begin
          state_d = nocnt_pkg::S_IDLE;
        end
      end
      default: state_d = nocnt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    fill_d     = fill_q;
    rd_addr_d  = rd_addr_q;
    cmp_v_d    = cmp_v_q;
    cmp_addr_d = cmp_addr_q;
    key_d      = key_q;
    len_d      = len_q;
    pend_d     = pend_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    case (state_q)
      nocnt_pkg::S_IDLE: begin
        if (accept) begin
          key_d       = key_in;
          len_d       = len_c;
          rd_addr_d   = '0;
          cmp_v_d     = 1'b0;
          pend_d      = '0;
          pend_d.used = to_used(fill_q);
          if (is_read) begin
            if (idx_ok) begin
              mem_re       = 1'b1;
              mem_raddr    = idx_ext[IDX_W-1:0];
              pend_d.index = cmd_i.read_index;
            end else begin
              pend_d.status = nocnt_pkg::ST_BAD_INDEX;
            end
          end else begin
            pend_d.status = nocnt_pkg::ST_EMPTY;
          end
        end
      end
      nocnt_pkg::S_RDW: begin
        pend_d.status = nocnt_pkg::ST_READ_OK;
        pend_d.count  = r_cnt;
        pend_d.words  = ALL_W'(r_key);
        pend_d.length = r_len;
      end
      nocnt_pkg::S_SCAN: begin
        cmp_v_d = 1'b0;
        if (hit) begin
          mem_we        = 1'b1;
          mem_waddr     = cmp_addr_q;
          mem_wdata     = {sat_cnt, r_len, r_key};
          pend_d.status = nocnt_pkg::ST_COUNTED;
          pend_d.index  = to_index(cmp_addr_q);
          pend_d.count  = sat_cnt;
        end else if (scan_more) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_addr_q[IDX_W-1:0];
          cmp_v_d    = 1'b1;
          cmp_addr_d = rd_addr_q[IDX_W-1:0];
          rd_addr_d  = rd_addr_q + 1'b1;
        end else if (full) begin
          pend_d.status = nocnt_pkg::ST_FULL;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = fill_q[IDX_W-1:0];
          mem_wdata     = {nocnt_pkg::COUNT_W'(1), len_q, key_q};
          fill_d        = fill_q + 1'b1;
          pend_d.status = nocnt_pkg::ST_ADDED;
          pend_d.index  = to_index(fill_q[IDX_W-1:0]);
          pend_d.count  = nocnt_pkg::COUNT_W'(1);
          pend_d.used   = to_used(fill_d);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nocnt_pkg::S_IDLE;
      fill_q      <= '0;
      rd_addr_q   <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_addr_q <= rd_addr_d;
      cmp_v_q   <= cmp_v_d;
      if (state_q == nocnt_pkg::S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_addr_q <= cmp_addr_d;
    key_q      <= key_d;
    len_q      <= len_d;
    pend_q     <= pend_d;
    if (state_q == nocnt_pkg::S_FIN && out_free) begin
      out_q <= pend_q;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.entry_index  = out_q.index;
  assign rsp_o.entry_count  = out_q.count;
  assign rsp_o.out_word0    = out_q.words[0];
  assign rsp_o.out_word1    = out_q.words[1];
  assign rsp_o.out_word2    = out_q.words[2];
  assign rsp_o.out_word3    = out_q.words[3];
  assign rsp_o.out_length   = out_q.length;
  assign rsp_o.entries_used = out_q.used;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_FILL)
    else $error("fill level above table depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1) && $past(mem_we))
    else $error("fill level moved without an append");

  a_write_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == nocnt_pkg::S_SCAN) && !mem_re)
    else $error("table write outside scan");

  a_cmp_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_v_q |-> (state_q == nocnt_pkg::S_SCAN))
    else $error("compare pending outside scan");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == nocnt_pkg::S_FIN))
    else $error("result loaded outside finish");
`endif

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_DEPTH = nocnt_pkg::DEF_TABLE_DEPTH;
  localparam int unsigned KEY_BYTES = nocnt_pkg::DEF_MAX_KEY_BYTES;
  localparam int unsigned POOL_N    = 24;

  typedef logic [nocnt_pkg::NAME_N-1:0][nocnt_pkg::NAME_W-1:0] name_words_t;

  typedef struct {
    logic                          pause;
    nocnt_pkg::cmd_e               command;
    name_words_t                   words;
    logic [nocnt_pkg::LEN_W-1:0]   length;
    logic [nocnt_pkg::INDEX_W-1:0] index;
  } name_cmd_t;

  logic clk_i;
  logic rst_ni;
  logic rsp_hold;
  logic steady;
  int   issued;
  int   received;
  int   mismatches;

  name_cmd_t       pending_cmds[$];
  nocnt_pkg::res_t expected_results[$];

  name_words_t                   stored_names  [TBL_DEPTH];
  logic [nocnt_pkg::LEN_W-1:0]   stored_lens   [TBL_DEPTH];
  logic [nocnt_pkg::COUNT_W-1:0] stored_counts [TBL_DEPTH];
  int unsigned                   table_fill = 0;

  name_words_t pool_words [POOL_N];
  int unsigned pool_lens  [POOL_N];

  nocnt_cmd_if cmd_bus ();
  nocnt_rsp_if rsp_bus ();

  name_occurrence_count_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  assign steady = (issued >= 400) && (issued < 520);

  function automatic nocnt_pkg::res_t count_table_step(input name_cmd_t item);
    nocnt_pkg::res_t  r;
    name_words_t      key;
    int unsigned      len;
    int unsigned      hit;
    r = '0;
    r.status = nocnt_pkg::ST_COUNTED;
    if (item.command == nocnt_pkg::CMD_READ) begin
      if (item.index < table_fill) begin
        r.status = nocnt_pkg::ST_READ_OK;
        r.index  = item.index;
        r.count  = stored_counts[item.index];
        r.words  = stored_names[item.index];
        r.length = stored_lens[item.index];
      end else begin
        r.status = nocnt_pkg::ST_BAD_INDEX;
      end
      r.used = table_fill[nocnt_pkg::USED_W-1:0];
      return r;
    end
    len = (item.length > KEY_BYTES) ? KEY_BYTES : item.length;
    if (len == 0) begin
      r.status = nocnt_pkg::ST_EMPTY;
      r.used   = table_fill[nocnt_pkg::USED_W-1:0];
      return r;
    end
    key = '0;
    for (int b = 0; b < len; b++) begin
      key[b/8][8*(b%8) +: 8] = item.words[b/8][8*(b%8) +: 8];
    end
    hit = table_fill;
    for (int i = 0; i < table_fill; i++) begin
      if (hit == table_fill && stored_lens[i] == len && stored_names[i] == key) begin
        hit = i;
      end
    end
    if (hit < table_fill) begin
      if (stored_counts[hit] != '1) begin
        stored_counts[hit] = stored_counts[hit] + 1;
      end
      r.status = nocnt_pkg::ST_COUNTED;
      r.index  = hit[nocnt_pkg::INDEX_W-1:0];
      r.count  = stored_counts[hit];
    end else if (table_fill >= TBL_DEPTH) begin
      r.status = nocnt_pkg::ST_FULL;
    end else begin
      stored_names[table_fill]  = key;
      stored_lens[table_fill]   = len[nocnt_pkg::LEN_W-1:0];
      stored_counts[table_fill] = 1;
      r.status   = nocnt_pkg::ST_ADDED;
      r.index    = table_fill[nocnt_pkg::INDEX_W-1:0];
      r.count    = 1;
      table_fill = table_fill + 1;
    end
    r.used = table_fill[nocnt_pkg::USED_W-1:0];
    return r;
  endfunction

  function automatic name_words_t random_words();
    name_words_t w;
    for (int i = 0; i < nocnt_pkg::NAME_N; i++) begin
      w[i] = {$urandom, $urandom};
    end
    return w;
  endfunction

  task automatic queue_count(input name_words_t words, input int unsigned len);
    name_cmd_t c;
    c.pause   = 1'b0;
    c.command = nocnt_pkg::CMD_COUNT;
    c.words   = words;
    c.length  = len[nocnt_pkg::LEN_W-1:0];
    c.index   = nocnt_pkg::INDEX_W'($urandom_range(255));
    pending_cmds.push_back(c);
  endtask

  task automatic queue_read(input int unsigned idx);
    name_cmd_t c;
    c.pause   = 1'b0;
    c.command = nocnt_pkg::CMD_READ;
    c.words   = random_words();
    c.length  = nocnt_pkg::LEN_W'($urandom_range(31));
    c.index   = idx[nocnt_pkg::INDEX_W-1:0];
    pending_cmds.push_back(c);
  endtask

  task automatic queue_pause();
    name_cmd_t c;
    c.pause   = 1'b1;
    c.command = nocnt_pkg::CMD_COUNT;
    c.words   = '0;
    c.length  = '0;
    c.index   = '0;
    pending_cmds.push_back(c);
  endtask

  // same name as pool entry k, random bytes past its length
  task automatic queue_pool_name(input int unsigned k);
    name_words_t w;
    int unsigned len;
    w   = random_words();
    len = pool_lens[k];
    for (int b = 0; b < len; b++) begin
      w[b/8][8*(b%8) +: 8] = pool_words[k][b/8][8*(b%8) +: 8];
    end
    if (len == KEY_BYTES && $urandom_range(1)) begin
      len = KEY_BYTES + 1;
    end
    queue_count(w, len);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", what, got, want));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // long receiver hold-off while commands keep coming
  initial begin
    rsp_hold = 1'b0;
    while (issued < 100) @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_commands
    name_cmd_t nxt;
    if (!rst_ni) begin
      cmd_bus.valid       <= 1'b0;
      cmd_bus.command     <= nocnt_pkg::CMD_COUNT;
      cmd_bus.name_word0  <= '0;
      cmd_bus.name_word1  <= '0;
      cmd_bus.name_word2  <= '0;
      cmd_bus.name_word3  <= '0;
      cmd_bus.name_length <= '0;
      cmd_bus.read_index  <= '0;
      issued              <= 0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        nxt.pause   = 1'b0;
        nxt.command = nocnt_pkg::cmd_e'(cmd_bus.command);
        nxt.words   = {cmd_bus.name_word3, cmd_bus.name_word2,
                       cmd_bus.name_word1, cmd_bus.name_word0};
        nxt.length  = cmd_bus.name_length;
        nxt.index   = cmd_bus.read_index;
        expected_results.push_back(count_table_step(nxt));
        issued <= issued + 1;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (pending_cmds.size() == 0 || (!steady && $urandom_range(99) < 15)) begin
          cmd_bus.valid <= 1'b0;
        end else if (pending_cmds[0].pause) begin
          cmd_bus.valid <= 1'b0;
          if (!cmd_bus.valid && issued == received) begin
            pending_cmds.delete(0);
          end
        end else begin
          nxt = pending_cmds.pop_front();
          cmd_bus.valid       <= 1'b1;
          cmd_bus.command     <= nxt.command;
          cmd_bus.name_word0  <= nxt.words[0];
          cmd_bus.name_word1  <= nxt.words[1];
          cmd_bus.name_word2  <= nxt.words[2];
          cmd_bus.name_word3  <= nxt.words[3];
          cmd_bus.name_length <= nxt.length;
          cmd_bus.read_index  <= nxt.index;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    nocnt_pkg::res_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      received      <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        received <= received + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(rsp_bus.status), 64'(want.status));
          check_field("entry_index", 64'(rsp_bus.entry_index), 64'(want.index));
          check_field("entry_count", 64'(rsp_bus.entry_count), 64'(want.count));
          check_field("out_word0", rsp_bus.out_word0, want.words[0]);
          check_field("out_word1", rsp_bus.out_word1, want.words[1]);
          check_field("out_word2", rsp_bus.out_word2, want.words[2]);
          check_field("out_word3", rsp_bus.out_word3, want.words[3]);
          check_field("out_length", 64'(rsp_bus.out_length), 64'(want.length));
          check_field("entries_used", 64'(rsp_bus.entries_used), 64'(want.used));
        end
      end
      rsp_bus.ready <= !rsp_hold && (steady || $urandom_range(99) >= 15);
    end
  end

  initial begin
    name_words_t w;
    int unsigned r;

    mismatches = 0;
    rst_ni     = 1'b0;

    // directed: empty table, empty names, zero bytes, over-long and ignored bytes
    queue_read(0);
    queue_count(random_words(), 0);
    queue_count('1, 0);
    w = random_words();
    w[0][7:0] = 8'h00;
    queue_count(w, 1);
    w = '0;
    w[0][7:0] = 8'hff;
    queue_count(w, 1);
    queue_count('1, KEY_BYTES);
    queue_count('1, KEY_BYTES + 1);
    w = '1;
    w[3][63:48] = '0;
    queue_count(w, KEY_BYTES);
    w = random_words();
    w[0][7:0] = 8'h00;
    queue_count(w, 1);
    queue_count('0, 2);
    w = '0;
    w[0] = '1;
    queue_count(w, 8);
    queue_count(w, 9);
    w[1] = {$urandom, $urandom};
    w[1][7:0] = 8'h00;
    queue_count(w, 9);
    queue_read(2);
    queue_read(5);
    queue_read(6);
    queue_read(255);
    queue_pause();

    for (int k = 0; k < POOL_N; k++) begin
      pool_words[k] = random_words();
      pool_lens[k]  = $urandom_range(1, KEY_BYTES);
    end

    // mostly repeats of a small set of names
    for (int n = 0; n < 260; n++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        queue_pool_name($urandom_range(POOL_N - 1));
      end else if (r < 65) begin
        queue_count(random_words(), $urandom_range(1, KEY_BYTES));
      end else if (r < 80) begin
        queue_read($urandom_range(40));
      end else if (r < 88) begin
        queue_read($urandom_range(255));
      end else if (r < 95) begin
        queue_count(random_words(), 0);
      end else begin
        queue_count(random_words(), KEY_BYTES + 1);
      end
      if (n % 90 == 89) begin
        queue_pause();
      end
    end

    // fill the table with fresh names
    for (int n = 0; n < 250; n++) begin
      r = $urandom_range(99);
      if (r < 90) begin
        queue_count(random_words(), $urandom_range(3, KEY_BYTES + 1));
      end else if (r < 96) begin
        queue_pool_name($urandom_range(POOL_N - 1));
      end else begin
        queue_read($urandom_range(255));
      end
    end
    queue_pause();

    // full table: matches still count, new names are dropped
    for (int n = 0; n < 180; n++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        queue_pool_name($urandom_range(POOL_N - 1));
      end else if (r < 65) begin
        queue_count(random_words(), $urandom_range(1, KEY_BYTES + 1));
      end else if (r < 92) begin
        queue_read($urandom_range(255));
      end else begin
        queue_count(random_words(), 0);
      end
      if (n % 60 == 59) begin
        queue_pause();
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (pending_cmds.size() != 0 || cmd_bus.valid || issued != received) begin
      @(negedge clk_i);
    end
    repeat (300) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
